// ===== hdl/smau_pkg.sv =====
// ----------------------------------------------------------------------------
// smau_pkg: shared types, constants and helpers
// Widths, request and status codes, controller states, command structs.
// ----------------------------------------------------------------------------
package smau_pkg;

  localparam int MaxDim   = 8;
  localparam int FracBits = 16;
  localparam int IdxW     = $clog2(MaxDim);
  localparam int AddrW    = 2 * IdxW;
  localparam int Depth    = MaxDim * MaxDim;
  localparam int DimW     = 4;
  localparam int ValW     = 32;
  localparam int ProdW    = 2 * ValW;
  localparam int ShW      = ProdW - FracBits;
  localparam int AccW     = ShW + IdxW;
  localparam int DivW     = ValW + FracBits;
  localparam int DivCntW  = $clog2(DivW + 1);
  localparam int CfgIdxW  = 2;

  typedef enum logic [2:0] {
    REQ_LOAD_A, REQ_LOAD_B, REQ_MUL, REQ_ADD, REQ_SUB, REQ_SCALE, REQ_DIV, REQ_TRANS
  } req_e;

  typedef enum logic [1:0] {
    ST_OK, ST_SIZE, ST_DIVZ
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_A_ROWS, CFG_A_COLS, CFG_B_ROWS, CFG_B_COLS
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EX, S_ACC, S_DIV, S_FIN, S_OUT, S_ERR
  } state_e;

  typedef struct packed {
    logic             rd;
    logic [AddrW-1:0] rd_a_addr;
    logic [AddrW-1:0] rd_b_addr;
    logic             ex;
    logic             acc_clr;
    logic             acc_en;
    logic             div_step;
    logic             fin;
    logic             out_ld;
    logic             wb;
    logic [IdxW-1:0]  out_row;
    logic [IdxW-1:0]  out_col;
    logic             out_last;
    status_e          out_status;
    req_e             op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
  } dp_sts_t;

  // saturate a sign-extended value to the 32-bit range
  function automatic logic signed [ValW-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (x > hi) return ValW'(hi);
    if (x < lo) return ValW'(lo);
    return x[ValW-1:0];
  endfunction

  // size register to (clamped size - 1)
  function automatic logic [IdxW-1:0] dim_m1(input logic [DimW-1:0] d);
    if (d == '0) return '0;
    if (d > DimW'(MaxDim)) return IdxW'(MaxDim - 1);
    return IdxW'(d - DimW'(1));
  endfunction

endpackage

// ===== hdl/smau_ctrl.sv =====
// ----------------------------------------------------------------------------
// smau_ctrl: command sequencer
// Size registers, element/term counters and the state machine driving the
// datapath.
// ----------------------------------------------------------------------------
module smau_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [smau_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [smau_pkg::DimW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  smau_pkg::req_e                    in_req_i,
  input  logic [smau_pkg::ValW-1:0]         in_value_i,
  output smau_pkg::dp_cmd_t                 cmd_o,
  input  smau_pkg::dp_sts_t                 sts_i
);

  smau_pkg::state_e state_q, state_d;
  logic [smau_pkg::DimW-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [smau_pkg::IdxW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  smau_pkg::req_e            op_q, op_d;
  smau_pkg::status_e         err_q, err_d;

  logic [smau_pkg::IdxW-1:0] ar_m1, ac_m1, br_m1, bc_m1;
  logic [smau_pkg::IdxW-1:0] rows_m1, cols_m1;
  logic                      fire, compute, bad_size, is_last, wb_op;

  assign ar_m1 = smau_pkg::dim_m1(a_rows_q);
  assign ac_m1 = smau_pkg::dim_m1(a_cols_q);
  assign br_m1 = smau_pkg::dim_m1(b_rows_q);
  assign bc_m1 = smau_pkg::dim_m1(b_cols_q);

  assign in_ready_o = (state_q == smau_pkg::S_IDLE);
  assign fire       = in_valid_i && in_ready_o;
  assign compute    = (in_req_i != smau_pkg::REQ_LOAD_A) && (in_req_i != smau_pkg::REQ_LOAD_B);

  always_comb begin
    unique case (in_req_i)
      smau_pkg::REQ_MUL:                 bad_size = (ac_m1 != br_m1);
      smau_pkg::REQ_ADD, smau_pkg::REQ_SUB: bad_size = (ar_m1 != br_m1) || (ac_m1 != bc_m1);
      default:                           bad_size = 1'b0;
    endcase
  end

  // result shape
  always_comb begin
    unique case (op_q)
      smau_pkg::REQ_MUL:   begin rows_m1 = ar_m1; cols_m1 = bc_m1; end
      smau_pkg::REQ_TRANS: begin rows_m1 = ac_m1; cols_m1 = ar_m1; end
      default:             begin rows_m1 = ar_m1; cols_m1 = ac_m1; end
    endcase
  end

  assign is_last = (i_q == rows_m1) && (j_q == cols_m1);
  assign wb_op   = (op_q == smau_pkg::REQ_ADD) || (op_q == smau_pkg::REQ_SUB) ||
                   (op_q == smau_pkg::REQ_SCALE) || (op_q == smau_pkg::REQ_DIV);

  // next state and counters
  always_comb begin
    state_d = state_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    op_d = op_q; err_d = err_q;
    unique case (state_q)
      smau_pkg::S_IDLE: begin
        if (fire && compute) begin
          op_d = in_req_i;
          i_d = '0; j_d = '0; k_d = '0;
          if (bad_size) begin
            err_d = smau_pkg::ST_SIZE;
            state_d = smau_pkg::S_ERR;
          end else if (in_req_i == smau_pkg::REQ_DIV && in_value_i == '0) begin
            err_d = smau_pkg::ST_DIVZ;
            state_d = smau_pkg::S_ERR;
          end else begin
            state_d = smau_pkg::S_RD;
          end
        end
      end
      smau_pkg::S_RD: state_d = smau_pkg::S_EX;
      smau_pkg::S_EX: begin
        unique case (op_q)
          smau_pkg::REQ_MUL:   state_d = smau_pkg::S_ACC;
          smau_pkg::REQ_DIV:   state_d = smau_pkg::S_DIV;
          smau_pkg::REQ_SCALE: state_d = smau_pkg::S_FIN;
          default:             state_d = smau_pkg::S_OUT;
        endcase
      end
      smau_pkg::S_ACC: begin
        if (k_q == ac_m1) begin
          k_d = '0;
          state_d = smau_pkg::S_FIN;
        end else begin
          k_d = k_q + 1'b1;
          state_d = smau_pkg::S_RD;
        end
      end
      smau_pkg::S_DIV: if (sts_i.div_done) state_d = smau_pkg::S_FIN;
      smau_pkg::S_FIN: state_d = smau_pkg::S_OUT;
      smau_pkg::S_OUT: begin
        if (sts_i.out_free) begin
          if (is_last) begin
            state_d = smau_pkg::S_IDLE;
          end else begin
            state_d = smau_pkg::S_RD;
            if (j_q == cols_m1) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        end
      end
      smau_pkg::S_ERR: if (sts_i.out_free) state_d = smau_pkg::S_IDLE;
      default: state_d = smau_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.op = op_q;
    cmd_o.out_row = i_q;
    cmd_o.out_col = j_q;
    cmd_o.out_last = is_last;
    cmd_o.out_status = smau_pkg::ST_OK;
    unique case (op_q)
      smau_pkg::REQ_MUL: begin
        cmd_o.rd_a_addr = {i_q, k_q};
        cmd_o.rd_b_addr = {k_q, j_q};
      end
      smau_pkg::REQ_TRANS: begin
        cmd_o.rd_a_addr = {j_q, i_q};
        cmd_o.rd_b_addr = {i_q, j_q};
      end
      default: begin
        cmd_o.rd_a_addr = {i_q, j_q};
        cmd_o.rd_b_addr = {i_q, j_q};
      end
    endcase
    unique case (state_q)
      smau_pkg::S_IDLE: cmd_o.acc_clr = 1'b1;
      smau_pkg::S_RD:   cmd_o.rd = 1'b1;
      smau_pkg::S_EX:   cmd_o.ex = 1'b1;
      smau_pkg::S_ACC:  cmd_o.acc_en = 1'b1;
      smau_pkg::S_DIV:  cmd_o.div_step = !sts_i.div_done;
      smau_pkg::S_FIN:  cmd_o.fin = 1'b1;
      smau_pkg::S_OUT: begin
        cmd_o.out_ld = sts_i.out_free;
        cmd_o.wb     = sts_i.out_free && wb_op;
      end
      smau_pkg::S_ERR: begin
        cmd_o.out_ld     = sts_i.out_free;
        cmd_o.out_row    = '0;
        cmd_o.out_col    = '0;
        cmd_o.out_last   = 1'b1;
        cmd_o.out_status = err_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= smau_pkg::S_IDLE;
      a_rows_q <= smau_pkg::DimW'(1);
      a_cols_q <= smau_pkg::DimW'(1);
      b_rows_q <= smau_pkg::DimW'(1);
      b_cols_q <= smau_pkg::DimW'(1);
      i_q <= '0; j_q <= '0; k_q <= '0;
      op_q  <= smau_pkg::REQ_LOAD_A;
      err_q <= smau_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d;
      op_q  <= op_d;
      err_q <= err_d;
      if (cfg_we_i) begin
        unique case (smau_pkg::cfg_e'(cfg_idx_i))
          smau_pkg::CFG_A_ROWS: a_rows_q <= cfg_wdata_i;
          smau_pkg::CFG_A_COLS: a_cols_q <= cfg_wdata_i;
          smau_pkg::CFG_B_ROWS: b_rows_q <= cfg_wdata_i;
          smau_pkg::CFG_B_COLS: b_cols_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smau_pkg::S_ACC |-> k_q <= ac_m1)
    else $error("term counter past inner size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smau_pkg::S_OUT |-> i_q <= rows_m1 && j_q <= cols_m1)
    else $error("element counter outside result shape");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smau_pkg::S_ERR |-> err_q != smau_pkg::ST_OK)
    else $error("error transfer without error code");

endmodule

// ===== hdl/smau_dp.sv =====
// ----------------------------------------------------------------------------
// smau_dp: matrix stores and arithmetic
// A and B memories, multiplier, accumulator, radix-2 divider, output register.
// ----------------------------------------------------------------------------
module smau_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  smau_pkg::dp_cmd_t               cmd_i,
  output smau_pkg::dp_sts_t               sts_o,
  input  logic                            in_fire_i,
  input  smau_pkg::req_e                  in_req_i,
  input  logic [smau_pkg::IdxW-1:0]       in_row_i,
  input  logic [smau_pkg::IdxW-1:0]       in_col_i,
  input  logic signed [smau_pkg::ValW-1:0] in_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [smau_pkg::IdxW-1:0]       out_row_o,
  output logic [smau_pkg::IdxW-1:0]       out_col_o,
  output logic signed [smau_pkg::ValW-1:0] out_value_o,
  output logic                            out_last_o,
  output smau_pkg::status_e               out_status_o
);

  localparam int VW = smau_pkg::ValW;

  logic signed [VW-1:0] a_mem [smau_pkg::Depth];
  logic signed [VW-1:0] b_mem [smau_pkg::Depth];
  logic signed [VW-1:0] a_rd_q, b_rd_q, scal_q, res_q;
  logic signed [smau_pkg::ProdW-1:0] prod_q;
  logic signed [smau_pkg::AccW-1:0]  acc_q;
  logic [smau_pkg::DivW-1:0]    div_dvd_q;
  logic [VW-1:0]                div_rem_q, div_dvs_q;
  logic                         div_neg_q;
  logic [smau_pkg::DivCntW-1:0] div_cnt_q;
  logic                         out_valid_q;

  logic                         ld_a, ld_b, a_we;
  logic [smau_pkg::AddrW-1:0]   a_waddr, ld_addr;
  logic signed [VW-1:0]         a_wdata;
  logic signed [smau_pkg::ShW-1:0] prod_sh;
  logic signed [VW:0]           sum, dif;
  logic [VW-1:0]                a_abs, s_abs;
  logic [VW:0]                  rem_sh, diff;
  logic                         ge;
  logic signed [smau_pkg::DivW:0] quo;

  assign ld_addr = {in_row_i, in_col_i};
  assign ld_a    = in_fire_i && (in_req_i == smau_pkg::REQ_LOAD_A);
  assign ld_b    = in_fire_i && (in_req_i == smau_pkg::REQ_LOAD_B);
  assign a_we    = ld_a || cmd_i.wb;
  assign a_waddr = cmd_i.wb ? {cmd_i.out_row, cmd_i.out_col} : ld_addr;
  assign a_wdata = cmd_i.wb ? res_q : in_value_i;

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem[a_waddr] <= a_wdata;
    if (ld_b) b_mem[ld_addr] <= in_value_i;
    if (cmd_i.rd) begin
      a_rd_q <= a_mem[cmd_i.rd_a_addr];
      b_rd_q <= b_mem[cmd_i.rd_b_addr];
    end
  end

  // floor shift of the product is a plain bit-select
  assign prod_sh = prod_q[smau_pkg::ProdW-1:smau_pkg::FracBits];
  assign sum     = {a_rd_q[VW-1], a_rd_q} + {b_rd_q[VW-1], b_rd_q};
  assign dif     = {a_rd_q[VW-1], a_rd_q} - {b_rd_q[VW-1], b_rd_q};
  assign a_abs   = a_rd_q[VW-1] ? VW'(-a_rd_q) : VW'(a_rd_q);
  assign s_abs   = scal_q[VW-1] ? VW'(-scal_q) : VW'(scal_q);

  // one quotient bit per step
  assign rem_sh = {div_rem_q, div_dvd_q[smau_pkg::DivW-1]};
  assign diff   = rem_sh - {1'b0, div_dvs_q};
  assign ge     = !diff[VW];
  assign quo    = div_neg_q ? -$signed({1'b0, div_dvd_q}) : $signed({1'b0, div_dvd_q});

  always_ff @(posedge clk_i) begin
    if (in_fire_i) scal_q <= in_value_i;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + {{smau_pkg::IdxW{prod_sh[smau_pkg::ShW-1]}}, prod_sh};
    end else if (cmd_i.fin && cmd_i.op == smau_pkg::REQ_MUL) begin
      acc_q <= '0;
    end
    if (cmd_i.ex) begin
      unique case (cmd_i.op)
        smau_pkg::REQ_MUL:   prod_q <= a_rd_q * b_rd_q;
        smau_pkg::REQ_SCALE: prod_q <= a_rd_q * scal_q;
        smau_pkg::REQ_ADD:   res_q <= smau_pkg::sat32({{(64-VW-1){sum[VW]}}, sum});
        smau_pkg::REQ_SUB:   res_q <= smau_pkg::sat32({{(64-VW-1){dif[VW]}}, dif});
        smau_pkg::REQ_DIV: begin
          div_dvd_q <= smau_pkg::DivW'(a_abs) << smau_pkg::FracBits;
          div_rem_q <= '0;
          div_dvs_q <= s_abs;
          div_neg_q <= a_rd_q[VW-1] ^ scal_q[VW-1];
        end
        default:             res_q <= a_rd_q;
      endcase
    end
    if (cmd_i.div_step) begin
      div_rem_q <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      div_dvd_q <= {div_dvd_q[smau_pkg::DivW-2:0], ge};
    end
    if (cmd_i.fin) begin
      unique case (cmd_i.op)
        smau_pkg::REQ_MUL:
          res_q <= smau_pkg::sat32({{(64-smau_pkg::AccW){acc_q[smau_pkg::AccW-1]}}, acc_q});
        smau_pkg::REQ_DIV:
          res_q <= smau_pkg::sat32({{(64-smau_pkg::DivW-1){quo[smau_pkg::DivW]}}, quo});
        default:
          res_q <= smau_pkg::sat32({{(64-smau_pkg::ShW){prod_sh[smau_pkg::ShW-1]}}, prod_sh});
      endcase
    end
    if (cmd_i.out_ld) begin
      out_row_o    <= cmd_i.out_row;
      out_col_o    <= cmd_i.out_col;
      out_value_o  <= (cmd_i.out_status == smau_pkg::ST_OK) ? res_q : '0;
      out_last_o   <= cmd_i.out_last;
      out_status_o <= cmd_i.out_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      if (cmd_i.out_ld) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.ex && cmd_i.op == smau_pkg::REQ_DIV) begin
        div_cnt_q <= smau_pkg::DivCntW'(smau_pkg::DivW);
      end else if (cmd_i.div_step && div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.div_done = (div_cnt_q == '0);

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ld_a && cmd_i.wb))
    else $error("load and write-back collide on A");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.div_step |-> div_cnt_q != '0)
    else $error("divider stepped after completion");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.out_ld |-> sts_o.out_free)
    else $error("output register overwritten");

endmodule

// ===== hdl/small_matrix_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// small_matrix_arithmetic_unit: Q16.16 matrix engine
// Loads A and B element by element; emits A*B, A+B, A-B, A*s, A/s or A^T.
// ----------------------------------------------------------------------------
// Sequence: a load gives no transfer. Per result element: add/sub/transpose read,
//   execute; scale read, multiply, finish; divide read, set up, the 48-step divider
//   and its done state, finish; multiply read, multiply, accumulate per a_cols term,
//   then finish; each then loads the output register, as do error results.
// Throughput: one command at a time; input is held off until the last result
//   has been loaded into the output register.
// Reset: async, active low; sizes go to 1, stores hold undefined contents.
module small_matrix_arithmetic_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [smau_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [smau_pkg::DimW-1:0]    cfg_wdata_i,
  // request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,  // elem_row[2:0], elem_col[5:3], value[37:6]
  input  logic [2:0]                   s_axis_tuser,  // req_type[2:0]
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [39:0]                  m_axis_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6]
  output logic                         m_axis_tlast,  // last
  output logic [1:0]                   m_axis_tuser   // status[1:0]
);

  smau_pkg::dp_cmd_t cmd;
  smau_pkg::dp_sts_t sts;
  smau_pkg::req_e    req;
  smau_pkg::status_e status;
  logic [smau_pkg::IdxW-1:0] out_row, out_col;
  logic signed [smau_pkg::ValW-1:0] out_value;
  logic in_fire;

  assign req     = smau_pkg::req_e'(s_axis_tuser);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // sequencer: sizes, counters and state machine
  smau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (req),
    .in_value_i  (s_axis_tdata[37:6]),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // stores, arithmetic and the output register
  smau_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_fire_i    (in_fire),
    .in_req_i     (req),
    .in_row_i     (s_axis_tdata[2:0]),
    .in_col_i     (s_axis_tdata[5:3]),
    .in_value_i   (s_axis_tdata[37:6]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast),
    .out_status_o (status)
  );

  assign m_axis_tdata = {2'b00, out_value, out_col, out_row};
  assign m_axis_tuser = status;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for small_matrix_arithmetic_unit
// Loads A and B, issues every command over several matrix sizes and checks
// each result transfer against a Q16.16 matrix predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected result transfer
  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] val;
    logic               last;
    smau_pkg::status_e  st;
  } res_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [smau_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [smau_pkg::DimW-1:0]     cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [39:0]                   s_axis_tdata  = '0;  // elem_row[2:0], elem_col[5:3], value[37:6]
  logic [2:0]                    s_axis_tuser  = '0;  // req_type[2:0]
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [39:0]                   m_axis_tdata;        // out_row[2:0], out_col[5:3], out_value[37:6]
  logic                          m_axis_tlast;
  logic [1:0]                    m_axis_tuser;        // status[1:0]

  small_matrix_arithmetic_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // bench copy of the block's state
  logic signed [31:0] mat_a [smau_pkg::Depth];
  logic signed [31:0] mat_b [smau_pkg::Depth];
  logic [3:0]         sz_ar = 4'd1, sz_ac = 4'd1, sz_br = 4'd1, sz_bc = 4'd1;

  res_t expected_q[$];
  int   n_mismatch = 0;
  int   n_results  = 0;
  int   n_cmds     = 0;
  int   n_loads    = 0;
  bit   no_idle    = 1'b0;   // set for the closing stretch: no idling either side
  int   quiet_cnt  = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int clamp_dim(logic [3:0] d);
    if (d == 0) return 1;
    if (d > smau_pkg::MaxDim) return smau_pkg::MaxDim;
    return int'(d);
  endfunction

  function automatic logic signed [31:0] clip32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic void push_res(int r, int c, logic signed [31:0] v, bit lst,
                                   smau_pkg::status_e st);
    res_t e;
    e.row = r[2:0]; e.col = c[2:0]; e.val = v; e.last = lst; e.st = st;
    expected_q.push_back(e);
  endfunction

  // apply one accepted request to the bench state and queue its results
  function automatic void predict_matrix_op(smau_pkg::req_e req, logic [2:0] er,
                                            logic [2:0] ec, logic signed [31:0] v);
    int     ar, ac, br, bc, ix;
    longint acc, p, r;
    ar = clamp_dim(sz_ar); ac = clamp_dim(sz_ac);
    br = clamp_dim(sz_br); bc = clamp_dim(sz_bc);
    case (req)
      smau_pkg::REQ_LOAD_A: mat_a[er*smau_pkg::MaxDim+ec] = v;
      smau_pkg::REQ_LOAD_B: mat_b[er*smau_pkg::MaxDim+ec] = v;
      smau_pkg::REQ_MUL: begin
        if (ac != br) begin
          push_res(0, 0, 0, 1'b1, smau_pkg::ST_SIZE);
        end else begin
          for (int i = 0; i < ar; i++)
            for (int j = 0; j < bc; j++) begin
              acc = 0;
              // each product floored to Q16.16, sum exact, one saturation
              for (int k = 0; k < ac; k++) begin
                p = longint'(mat_a[i*smau_pkg::MaxDim+k]) *
                    longint'(mat_b[k*smau_pkg::MaxDim+j]);
                acc += p >>> smau_pkg::FracBits;
              end
              push_res(i, j, clip32(acc), i == ar-1 && j == bc-1, smau_pkg::ST_OK);
            end
        end
      end
      smau_pkg::REQ_TRANS: begin
        for (int i = 0; i < ac; i++)
          for (int j = 0; j < ar; j++)
            push_res(i, j, mat_a[j*smau_pkg::MaxDim+i], i == ac-1 && j == ar-1,
                     smau_pkg::ST_OK);
      end
      default: begin
        if ((req == smau_pkg::REQ_ADD || req == smau_pkg::REQ_SUB) &&
            (ar != br || ac != bc)) begin
          push_res(0, 0, 0, 1'b1, smau_pkg::ST_SIZE);
        end else if (req == smau_pkg::REQ_DIV && v == 0) begin
          push_res(0, 0, 0, 1'b1, smau_pkg::ST_DIVZ);
        end else begin
          for (int i = 0; i < ar; i++)
            for (int j = 0; j < ac; j++) begin
              ix = i*smau_pkg::MaxDim + j;
              case (req)
                smau_pkg::REQ_ADD: r = longint'(mat_a[ix]) + longint'(mat_b[ix]);
                smau_pkg::REQ_SUB: r = longint'(mat_a[ix]) - longint'(mat_b[ix]);
                smau_pkg::REQ_SCALE:
                  r = (longint'(mat_a[ix]) * longint'(v)) >>> smau_pkg::FracBits;
                default: r = (longint'(mat_a[ix]) * 65536) / longint'(v); // toward zero
              endcase
              mat_a[ix] = clip32(r);   // in-place write-back
              push_res(i, j, mat_a[ix], i == ar-1 && j == ac-1, smau_pkg::ST_OK);
            end
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_request(smau_pkg::req_e req, logic [2:0] er, logic [2:0] ec,
                              logic signed [31:0] v);
    if (!no_idle && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {2'b00, v, ec, er};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_matrix_op(req, er, ec, v);
    if (req inside {smau_pkg::REQ_LOAD_A, smau_pkg::REQ_LOAD_B}) n_loads++;
    else n_cmds++;
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // all four size registers in one go, only while idle
  task automatic set_sizes(logic [3:0] ar, logic [3:0] ac, logic [3:0] br, logic [3:0] bc);
    logic [3:0]     vals [4];
    smau_pkg::cfg_e ids  [4];
    vals = '{ar, ac, br, bc};
    ids  = '{smau_pkg::CFG_A_ROWS, smau_pkg::CFG_A_COLS,
             smau_pkg::CFG_B_ROWS, smau_pkg::CFG_B_COLS};
    drain_results();
    for (int k = 0; k < 4; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= ids[k];
      cfg_wdata_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sz_ar = ar; sz_ac = ac; sz_br = br; sz_bc = bc;
  endtask

  // mostly modest Q16.16 values so results do not all saturate
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0:       return $urandom();
      1:       return 32'sh7FFF_FFFF - $urandom_range(3);
      2:       return 32'sh8000_0000 + $urandom_range(3);
      default: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // every entry of both stores written, so no read can hit an unwritten word
  task automatic test_fill_stores();
    set_sizes(4'd8, 4'd8, 4'd8, 4'd8);
    for (int e = 0; e < smau_pkg::Depth; e++) begin
      send_request(smau_pkg::REQ_LOAD_A, e[5:3], e[2:0], rand_value());
      send_request(smau_pkg::REQ_LOAD_B, e[5:3], e[2:0], rand_value());
    end
  endtask

  task automatic test_directed();
    // field extremes in the corners, then every command at full size
    send_request(smau_pkg::REQ_LOAD_A, 3'd0, 3'd0, 32'sh7FFF_FFFF);
    send_request(smau_pkg::REQ_LOAD_A, 3'd7, 3'd7, 32'sh8000_0000);
    send_request(smau_pkg::REQ_LOAD_B, 3'd0, 3'd0, 32'sh8000_0000);
    send_request(smau_pkg::REQ_LOAD_B, 3'd7, 3'd7, 32'sh7FFF_FFFF);
    send_request(smau_pkg::REQ_MUL,   3'd7, 3'd7, 32'sh0);
    send_request(smau_pkg::REQ_ADD,   3'd0, 3'd0, 32'sh0);
    send_request(smau_pkg::REQ_SUB,   3'd0, 3'd0, 32'sh0);
    send_request(smau_pkg::REQ_SCALE, 3'd0, 3'd0, 32'sh0000_8000);
    send_request(smau_pkg::REQ_SCALE, 3'd0, 3'd0, 32'sh8000_0000);
    send_request(smau_pkg::REQ_DIV,   3'd0, 3'd0, 32'sh0002_0000);
    send_request(smau_pkg::REQ_DIV,   3'd0, 3'd0, -32'sd1);
    send_request(smau_pkg::REQ_DIV,   3'd0, 3'd0, 32'sh0);     // zero divisor
    send_request(smau_pkg::REQ_TRANS, 3'd0, 3'd0, 32'sh0);
    // size 0 reads as 1, size 15 as 8: mismatches everywhere but transpose
    set_sizes(4'd0, 4'd15, 4'd3, 4'd2);
    send_request(smau_pkg::REQ_MUL,   3'd0, 3'd0, 32'sh0);
    send_request(smau_pkg::REQ_ADD,   3'd0, 3'd0, 32'sh0);
    send_request(smau_pkg::REQ_SUB,   3'd0, 3'd0, 32'sh0);
    send_request(smau_pkg::REQ_TRANS, 3'd0, 3'd0, 32'sh0);
    // non-square product
    set_sizes(4'd2, 4'd3, 4'd3, 4'd4);
    send_request(smau_pkg::REQ_MUL,   3'd0, 3'd0, 32'sh0);
  endtask

  function automatic logic [3:0] rand_size();
    case ($urandom_range(7))
      0:       return 4'd0;
      1:       return 4'($urandom_range(15, 9));
      2:       return 4'd8;
      default: return 4'($urandom_range(4, 1));
    endcase
  endfunction

  task automatic run_phase(int n_items);
    logic [3:0]         ar, ac, br, bc;
    smau_pkg::req_e     req;
    logic signed [31:0] v;
    ar = rand_size(); ac = rand_size();
    // bias towards compatible shapes so commands get past the size check
    case ($urandom_range(3))
      0:       begin br = ac; bc = rand_size(); end
      1:       begin br = ar; bc = ac; end
      default: begin br = rand_size(); bc = rand_size(); end
    endcase
    set_sizes(ar, ac, br, bc);
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(2) != 0) req = smau_pkg::req_e'($urandom_range(1));
      else req = smau_pkg::req_e'($urandom_range(7, 2));
      v = rand_value();
      if (req == smau_pkg::REQ_DIV && $urandom_range(5) == 0) v = 0;
      if (req == smau_pkg::REQ_SCALE && $urandom_range(1) == 0)
        v = $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
      send_request(req, 3'($urandom_range(7)), 3'($urandom_range(7)), v);
      // occasional hold-off until the block has delivered everything
      if ($urandom_range(15) == 0) drain_results();
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 12; p++) run_phase(21);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int p = 0; p < 2; p++) run_phase(30);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, one assignment per edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (quiet_cnt > 0) begin
      quiet_cnt     <= quiet_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(5) == 0) begin
      quiet_cnt     <= $urandom_range(13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_results
    res_t e;
    logic signed [31:0] got_v;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      got_v = m_axis_tdata[37:6];
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: result with nothing expected: row %0d col %0d val %h",
                   $realtime, m_axis_tdata[2:0], m_axis_tdata[5:3], got_v);
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[2:0] !== e.row || m_axis_tdata[5:3] !== e.col ||
            got_v !== e.val || m_axis_tlast !== e.last || m_axis_tuser !== e.st) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: exp r%0d c%0d %h last %b st %0d, got r%0d c%0d %h last %b st %0d",
                     $realtime, e.row, e.col, e.val, e.last, e.st, m_axis_tdata[2:0],
                     m_axis_tdata[5:3], got_v, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  // watchdog: too long without any transfer on either side
  int stuck_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (!s_axis_tvalid && expected_q.size() == 0))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_stores();
    test_directed();
    test_random();
    test_back_to_back();
    drain_results();
    if (expected_q.size() != 0) n_mismatch++;
    $display("Covered %0d loads and %0d commands over mixed sizes, %0d results checked.",
             n_loads, n_cmds, n_results);
    if (n_mismatch == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
